[hdl/mid_pkg.sv]
// Package with the per-channel state type, status codes and the filter update function.
package mid_pkg;

    localparam logic       FUNC_POLL  = 1'b0;
    localparam logic       FUNC_INIT  = 1'b1;

    localparam logic [1:0] ST_NORMAL  = 2'd0;
    localparam logic [1:0] ST_EVENT   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic [7:0] MIN_SETTLE = 8'd2;

    typedef struct packed {
        logic [7:0] last_sample;
        logic [7:0] candidate_level;
        logic [7:0] settle_count;
        logic [7:0] debounced_level;
    } chan_state_t;

    typedef struct packed {
        chan_state_t state;
        logic        event_hit;
    } poll_result_t;

    // One poll step of a chatter filter.
    function automatic poll_result_t poll_step(chan_state_t cur, logic [7:0] smp,
                                               logic [7:0] ticks);
        poll_result_t res;
        res                       = '0;
        res.state                 = cur;
        res.state.last_sample     = smp;
        if (cur.settle_count == 8'd0)
        begin
            if (smp != cur.last_sample)
            begin
                res.state.settle_count    = 8'd1;
                res.state.candidate_level = smp;
            end
        end
        else if (cur.settle_count < ticks)
        begin
            res.state.settle_count = 8'(cur.settle_count + 8'd1);
        end
        else if (smp == cur.candidate_level)
        begin
            res.state.settle_count    = 8'd0;
            res.state.debounced_level = smp;
            res.event_hit             = 1'b1;
        end
        else
        begin
            res.state.settle_count    = 8'd1;
            res.state.candidate_level = smp;
        end
        return res;
    endfunction

endpackage

[hdl/multichannel_input_debouncer_top.sv]
// Top level of the multichannel input debouncer: state memory, update stage and result register.
//
//   channel | direction | handshake          | fields
//   --------+-----------+--------------------+-------------------------------------------
//   in      | to block  | in_valid, in_stall | func, channel, sample, settle_ticks
//   out     | from block| out_valid,out_stall| status, stable_level
//
// An item's result is registered in the result register once the item moves on from the update
// stage, and one item is accepted every cycle unless the input stalls: the state memory is read
// when the item is accepted and written when its result is registered, and a bypass register
// covers an item that follows one on the same channel.
// Reset clears the per-channel valid bits at once, so no clearing pass is needed.
// A stall on the output holds the result register and then the update stage; the input
// stalls only when the update stage is full and cannot move on.
module multichannel_input_debouncer_top
    import mid_pkg::*;
#(
    parameter int CHANNEL_COUNT = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       func,
    input  logic [7:0] channel,
    input  logic [7:0] sample,
    input  logic [7:0] settle_ticks,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic [7:0] stable_level
);

    localparam int         CH_W     = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam logic [8:0] CH_LIMIT = 9'(CHANNEL_COUNT);

    chan_state_t             mem [CHANNEL_COUNT];
    logic [CHANNEL_COUNT-1:0] written_reg;

    logic              s1_valid_reg;
    logic              func_reg;
    logic [7:0]        channel_reg;
    logic [7:0]        sample_reg;
    logic [7:0]        ticks_reg;
    chan_state_t       rd_reg;
    logic              rd_written_reg;

    logic              byp_valid_reg;
    logic [CH_W-1:0]   byp_idx_reg;
    chan_state_t       byp_data_reg;

    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [7:0]        level_reg;

    logic              in_accept;
    logic              advance;
    logic [CH_W-1:0]   in_idx;
    logic [CH_W-1:0]   s1_idx;
    logic              s1_in_range;
    chan_state_t       cur_state;
    chan_state_t       new_state;
    poll_result_t      poll_res;
    logic              mem_wr;
    logic [1:0]        status_next;
    logic [7:0]        level_next;

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign in_idx    = channel[CH_W-1:0];
    assign s1_idx    = channel_reg[CH_W-1:0];
    assign s1_in_range = ({1'b0, channel_reg} < CH_LIMIT);

    always_comb
    begin
        // The latest write to this channel may not be in the read data yet.
        if (byp_valid_reg && (byp_idx_reg == s1_idx))
        begin
            cur_state = byp_data_reg;
        end
        else if (rd_written_reg)
        begin
            cur_state = rd_reg;
        end
        else
        begin
            cur_state = '0;
        end

        poll_res    = poll_step(cur_state, sample_reg, ticks_reg);
        new_state   = cur_state;
        mem_wr      = 1'b0;
        status_next = ST_NORMAL;
        level_next  = cur_state.debounced_level;

        if (!s1_in_range)
        begin
            status_next = ST_INVALID;
            level_next  = 8'd0;
        end
        else if (func_reg == FUNC_INIT)
        begin
            new_state.last_sample     = sample_reg;
            new_state.candidate_level = sample_reg;
            new_state.settle_count    = 8'd0;
            new_state.debounced_level = sample_reg;
            mem_wr                    = s1_valid_reg && advance;
            level_next                = sample_reg;
        end
        else if (ticks_reg < MIN_SETTLE)
        begin
            status_next = ST_INVALID;
        end
        else
        begin
            new_state   = poll_res.state;
            mem_wr      = s1_valid_reg && advance;
            status_next = poll_res.event_hit ? ST_EVENT : ST_NORMAL;
            level_next  = poll_res.state.debounced_level;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[s1_idx] <= new_state;
        end
        if (in_accept)
        begin
            rd_reg <= mem[in_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (mem_wr)
            begin
                written_reg[s1_idx] <= 1'b1;
            end
            if (in_accept)
            begin
                rd_written_reg <= written_reg[in_idx];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg    <= func;
            channel_reg <= channel;
            sample_reg  <= sample;
            ticks_reg   <= settle_ticks;
        end
        if (mem_wr)
        begin
            byp_idx_reg  <= s1_idx;
            byp_data_reg <= new_state;
        end
        if (s1_valid_reg && advance)
        begin
            status_reg <= status_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (mem_wr)
            begin
                byp_valid_reg <= 1'b1;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign stable_level = level_reg;

`ifndef ASSERT_OFF
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (status_reg == ST_NORMAL || status_reg == ST_EVENT ||
                           status_reg == ST_INVALID))
        else $error("result carries an undefined status code");

    a_range_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && advance && !s1_in_range) |=>
            (out_valid_reg && status_reg == ST_INVALID && level_reg == 8'd0))
        else $error("out-of-range channel did not give an invalid result");

    a_no_wr_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr |-> (s1_in_range && s1_valid_reg))
        else $error("state written for an item that must not change state");

    a_bypass_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr |=> (byp_valid_reg && byp_idx_reg == $past(s1_idx)))
        else $error("bypass register does not hold the latest written channel");
`endif

endmodule

[tb/debounce_checker.sv]
// Checker for the debouncer bank: predicts every result from the accepted items and compares.
module debounce_checker
    import mid_pkg::*;
#(
    parameter int CHANNEL_COUNT = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic       func,
    input  logic [7:0] channel,
    input  logic [7:0] sample,
    input  logic [7:0] settle_ticks,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [1:0] status,
    input  logic [7:0] stable_level,
    output int         mismatches,
    output int         pending_reports
);

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] level;
    } filter_report_t;

    chan_state_t    filter_bank [CHANNEL_COUNT];
    filter_report_t reports_due [$];
    filter_report_t due;
    int             err_seen = 0;

    // Applies one item to the private copy of the filter bank and returns the report.
    function automatic filter_report_t debounce_predict(logic fn, logic [7:0] ch,
                                                        logic [7:0] smp, logic [7:0] ticks);
        filter_report_t rep;
        chan_state_t    cur;
        chan_state_t    nxt;
        rep.status = ST_NORMAL;
        rep.level  = 8'd0;
        if (ch >= CHANNEL_COUNT)
        begin
            rep.status = ST_INVALID;
            return rep;
        end
        cur = filter_bank[ch];
        nxt = cur;
        if (fn == FUNC_INIT)
        begin
            nxt.last_sample     = smp;
            nxt.candidate_level = smp;
            nxt.settle_count    = 8'd0;
            nxt.debounced_level = smp;
        end
        else if (ticks < MIN_SETTLE)
        begin
            rep.status = ST_INVALID;
        end
        else
        begin
            nxt.last_sample = smp;
            if (cur.settle_count == 8'd0)
            begin
                if (smp != cur.last_sample)
                begin
                    nxt.settle_count    = 8'd1;
                    nxt.candidate_level = smp;
                end
            end
            else if (cur.settle_count < ticks)
            begin
                nxt.settle_count = 8'(cur.settle_count + 8'd1);
            end
            // A count at or past the settle count decides, even if the count was lowered.
            else if (smp == cur.candidate_level)
            begin
                nxt.settle_count    = 8'd0;
                nxt.debounced_level = smp;
                rep.status          = ST_EVENT;
            end
            else
            begin
                nxt.settle_count    = 8'd1;
                nxt.candidate_level = smp;
            end
        end
        filter_bank[ch] = nxt;
        rep.level       = nxt.debounced_level;
        return rep;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                filter_bank[i] = '0;
            end
            reports_due.delete();
            mismatches      <= err_seen;
            pending_reports <= 0;
        end
        else
        begin
            // The result side is checked first: an item accepted now cannot have a result yet.
            if (out_valid && !out_stall)
            begin
                if (reports_due.size() == 0)
                begin
                    err_seen++;
                    if (err_seen <= 10)
                    begin
                        $display("ERROR: result with nothing expected: status %0d level %02h",
                                 status, stable_level);
                    end
                end
                else
                begin
                    due = reports_due.pop_front();
                    if (status !== due.status || stable_level !== due.level)
                    begin
                        err_seen++;
                        if (err_seen <= 10)
                        begin
                            $display("ERROR: status exp %0d got %0d, level exp %02h got %02h",
                                     due.status, status, due.level, stable_level);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                reports_due.push_back(debounce_predict(func, channel, sample, settle_ticks));
            end
            mismatches      <= err_seen;
            pending_reports <= reports_due.size();
        end
    end

endmodule

[tb/tb_multichannel_input_debouncer_top.sv]
// Testbench top for the multichannel input debouncer: clock, reset, traffic and verdict.
module tb_multichannel_input_debouncer_top;
    import mid_pkg::*;

    localparam int CHANNEL_COUNT  = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 10;

    logic       clk;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_stall;
    logic       func         = FUNC_POLL;
    logic [7:0] channel      = 8'd0;
    logic [7:0] sample       = 8'd0;
    logic [7:0] settle_ticks = 8'd0;
    logic       out_valid;
    logic       out_stall    = 1'b0;
    logic [1:0] status;
    logic [7:0] stable_level;

    int         mismatches;
    int         pending_reports;

    bit         hold_request = 1'b0;
    logic [7:0] chan_level [CHANNEL_COUNT] = '{default: 8'd0};
    logic [7:0] chan_ticks [CHANNEL_COUNT] = '{default: 8'd2};

    int         items_in     = 0;
    int         results_out  = 0;
    int         events_seen  = 0;
    int         invalid_seen = 0;
    int         idle_cycles  = 0;

    multichannel_input_debouncer_top #(
        .CHANNEL_COUNT(CHANNEL_COUNT)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .channel     (channel),
        .sample      (sample),
        .settle_ticks(settle_ticks),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .stable_level(stable_level)
    );

    debounce_checker #(
        .CHANNEL_COUNT(CHANNEL_COUNT)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .channel        (channel),
        .sample         (sample),
        .settle_ticks   (settle_ticks),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .stable_level   (stable_level),
        .mismatches     (mismatches),
        .pending_reports(pending_reports)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Presents one item and returns at the edge where it is taken.
    task automatic offer_item(logic f, logic [7:0] c, logic [7:0] s, logic [7:0] t);
        in_valid     <= 1'b1;
        func         <= f;
        channel      <= c;
        sample       <= s;
        settle_ticks <= t;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Mostly clean polls that follow a per-channel level with some chatter, plus
    // inits, invalid requests and fully random items.
    task automatic pick_item(output logic f, output logic [7:0] c, output logic [7:0] s,
                             output logic [7:0] t);
        int roll;
        roll = $urandom_range(0, 99);
        f    = FUNC_POLL;
        c    = 8'($urandom_range(0, CHANNEL_COUNT - 1));
        if (roll < 4)
        begin
            f = FUNC_INIT;
            s = 8'($urandom);
            t = 8'($urandom);
            chan_level[c] = s;
        end
        else if (roll < 7)
        begin
            c = 8'($urandom_range(CHANNEL_COUNT, 255));
            f = 1'($urandom_range(0, 1));
            s = 8'($urandom);
            t = 8'($urandom);
        end
        else if (roll < 10)
        begin
            s = chan_level[c];
            t = 8'($urandom_range(0, 1));
        end
        else if (roll < 14)
        begin
            s = 8'($urandom);
            t = 8'($urandom);
        end
        else
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                chan_level[c] = 8'($urandom);
            end
            if ($urandom_range(0, 19) == 0)
            begin
                chan_ticks[c] = 8'($urandom_range(2, 6));
            end
            s = ($urandom_range(0, 9) == 0) ? 8'($urandom) : chan_level[c];
            t = chan_ticks[c];
        end
    endtask

    task automatic run_traffic(int n, bit gapless);
        int         burst_left;
        int         gap;
        logic       f;
        logic [7:0] c;
        logic [7:0] s;
        logic [7:0] t;
        burst_left = $urandom_range(1, 40);
        for (int i = 0; i < n; i++)
        begin
            pick_item(f, c, s, t);
            offer_item(f, c, s, t);
            burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (!gapless && gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    // Output side: stall patterns picked anew for every segment, and the long hold-off.
    initial
    begin : receiver
        int seg_left;
        int mode;
        seg_left = 0;
        mode     = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(10, 80);
                end
                seg_left--;
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 9) < 3);
                    2:       out_stall <= ($urandom_range(0, 9) < 7);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    // Traffic counters and the watchdog on cycles in which nothing moves.
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            items_in++;
        end
        if (out_valid && !out_stall)
        begin
            results_out++;
            if (status == ST_EVENT)
            begin
                events_seen++;
            end
            if (status == ST_INVALID)
            begin
                invalid_seen++;
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no traffic for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes, inits and both kinds of invalid request.
        offer_item(FUNC_INIT, 8'd0, 8'hFF, 8'd0);
        offer_item(FUNC_INIT, 8'd7, 8'h00, 8'hFF);
        offer_item(FUNC_INIT, 8'd255, 8'h3C, 8'd4);
        offer_item(FUNC_POLL, 8'd8, 8'hFF, 8'd2);
        offer_item(FUNC_POLL, 8'd3, 8'h81, 8'd0);
        offer_item(FUNC_POLL, 8'd3, 8'h81, 8'd1);
        // Confirmation at the minimum settle count.
        offer_item(FUNC_POLL, 8'd1, 8'hA5, 8'd2);
        offer_item(FUNC_POLL, 8'd1, 8'hA5, 8'd2);
        offer_item(FUNC_POLL, 8'd1, 8'hA5, 8'd2);
        // A differing sample at the settle count relatches the candidate.
        offer_item(FUNC_POLL, 8'd2, 8'h11, 8'd2);
        offer_item(FUNC_POLL, 8'd2, 8'h22, 8'd2);
        offer_item(FUNC_POLL, 8'd2, 8'h33, 8'd2);
        offer_item(FUNC_POLL, 8'd2, 8'h33, 8'd2);
        offer_item(FUNC_POLL, 8'd2, 8'h33, 8'd2);
        // Settle count lowered below the running count.
        offer_item(FUNC_POLL, 8'd4, 8'h5A, 8'd200);
        offer_item(FUNC_POLL, 8'd4, 8'h5A, 8'd200);
        offer_item(FUNC_POLL, 8'd4, 8'h5A, 8'd200);
        offer_item(FUNC_POLL, 8'd4, 8'h5A, 8'd2);
        // Unchanged sample on an idle channel, then the largest settle count.
        offer_item(FUNC_POLL, 8'd5, 8'h00, 8'd3);
        offer_item(FUNC_POLL, 8'd6, 8'hFF, 8'd255);
        offer_item(FUNC_POLL, 8'd6, 8'hFF, 8'd255);
        offer_item(FUNC_POLL, 8'd0, 8'h00, 8'd2);

        run_traffic(800, 1'b0);

        // Output held off while items keep coming, so the input has to stall.
        hold_request = 1'b1;
        run_traffic(80, 1'b1);

        // The pending count seen here is registered, so let the last item register first.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_reports != 0)
        begin
            @(posedge clk);
        end

        run_traffic(970, 1'b0);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_reports != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Summary: %0d items in, %0d results out, %0d confirmed changes, %0d invalid",
                 items_in, results_out, events_seen, invalid_seen);
        $display("Traffic used bursts, gaps, output stalls, a long hold-off and a full drain.");
        if (mismatches == 0 && pending_reports == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches, pending_reports);
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[multichannel_input_debouncer_top.f]
hdl/mid_pkg.sv
hdl/multichannel_input_debouncer_top.sv
tb/debounce_checker.sv
tb/tb_multichannel_input_debouncer_top.sv
